// ----- sv/ptt_pkg.sv -----
// shared types, codes and helpers for the periodic timer table
`default_nettype none

package ptt_pkg;

    localparam int          MAX_TIMERS_DEF = 16;
    localparam logic [15:0] MIN_PERIOD_RST = 16'd10;

    localparam logic [2:0] CMD_SET      = 3'd0;
    localparam logic [2:0] CMD_KILL     = 3'd1;
    localparam logic [2:0] CMD_KILL_ALL = 3'd2;
    localparam logic [2:0] CMD_RESET    = 3'd3;
    localparam logic [2:0] CMD_CHECK    = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EXISTS  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_FIRED   = 3'd3;
    localparam logic [2:0] ST_WAITING = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  owner;
        logic [31:0] tid;
        logic [31:0] period;
        logic [31:0] now;
    } t_cmd_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  fired_owner;
        logic [31:0] fired_id;
        logic [30:0] remaining;
    } t_result;

    typedef struct packed {
        logic [7:0]  owner;
        logic [31:0] tid;
        logic [31:0] period;
        logic [31:0] deadline;
        logic [31:0] arm_stamp;
    } t_entry;

    typedef struct packed {
        logic   found;
        t_entry ent;
    } t_pick;

    typedef struct packed {
        logic        clear;
        logic        eval;
        logic        entry_valid;
        logic [7:0]  owner;
        logic [31:0] tid;
    } t_scan_ctl;

    // wrap-safe order: a lies before b
    function automatic logic precedes(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

endpackage

`default_nettype wire

// ----- sv/ptt_store.sv -----
// entry memory of the timer table, one write port and one registered read port
`default_nettype none

module ptt_store #(
    parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF,
    parameter int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
    input  wire                    i_clk,
    input  wire                    i_we,
    input  wire  [IDX_W-1:0]       i_waddr,
    input  wire ptt_pkg::t_entry   i_wdata,
    input  wire  [IDX_W-1:0]       i_raddr,
    output ptt_pkg::t_entry        o_rdata
);

    ptt_pkg::t_entry mem [MAX_TIMERS];
    ptt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- sv/ptt_scan.sv -----
// shared match, free-slot and earliest-deadline compare unit, one entry per cycle
`default_nettype none

module ptt_scan #(
    parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF,
    parameter int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire ptt_pkg::t_scan_ctl  i_ctl,
    input  wire ptt_pkg::t_entry     i_rd,
    input  wire  [IDX_W-1:0]         i_idx,
    output ptt_pkg::t_pick           o_match,
    output logic [IDX_W-1:0]         o_match_slot,
    output logic                     o_free_found,
    output logic [IDX_W-1:0]         o_free_slot,
    output ptt_pkg::t_pick           o_best,
    output logic [IDX_W-1:0]         o_best_slot
);

    logic             r_match_found;
    logic             r_free_found;
    logic             r_best_found;
    ptt_pkg::t_entry  r_match_ent;
    ptt_pkg::t_entry  r_best_ent;
    logic [IDX_W-1:0] r_match_slot;
    logic [IDX_W-1:0] r_free_slot;
    logic [IDX_W-1:0] r_best_slot;

    logic hit;
    logic better;

    assign hit = i_ctl.entry_valid && (i_rd.owner == i_ctl.owner)
                 && (i_rd.tid == i_ctl.tid);

    assign better = i_ctl.entry_valid && (!r_best_found
                    || ptt_pkg::precedes(i_rd.deadline, r_best_ent.deadline)
                    || ((i_rd.deadline == r_best_ent.deadline)
                        && ptt_pkg::precedes(i_rd.arm_stamp, r_best_ent.arm_stamp)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_best_found  <= 1'b0;
        end else if (i_ctl.clear) begin
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_best_found  <= 1'b0;
        end else if (i_ctl.eval) begin
            if (hit) begin
                r_match_found <= 1'b1;
            end
            if (!i_ctl.entry_valid) begin
                r_free_found <= 1'b1;
            end
            if (better) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            if (hit && !r_match_found) begin
                r_match_ent  <= i_rd;
                r_match_slot <= i_idx;
            end
            if (!i_ctl.entry_valid && !r_free_found) begin
                r_free_slot <= i_idx;
            end
            if (better) begin
                r_best_ent  <= i_rd;
                r_best_slot <= i_idx;
            end
        end
    end

    assign o_match      = '{found: r_match_found, ent: r_match_ent};
    assign o_match_slot = r_match_slot;
    assign o_free_found = r_free_found;
    assign o_free_slot  = r_free_slot;
    assign o_best       = '{found: r_best_found, ent: r_best_ent};
    assign o_best_slot  = r_best_slot;

endmodule

`default_nettype wire

// ----- sv/periodic_timer_table.sv -----
// top level of the periodic timer table: sequencer, valid bits and result register
//
// usage
//   a command item is taken on start while busy is low; busy then stays high
//   while the sequencer sweeps every slot of the entry memory, one slot per
//   cycle through a single shared match and deadline compare unit
//   the result item appears on o_result with o_strobe high for one cycle,
//   registered in the done state that follows the slot sweep
//   busy falls in the same cycle as the strobe, so a new command can be taken
//   only once the result is out, never during a sweep; the slot sweep sets the
//   time between commands, which grows with the number of table entries
//   the receiver cannot stall: o_result holds each result until the next strobe
//   the user writes min_period through i_cfg_we / i_cfg_wdata while busy is low,
//   the block does not enforce it; a synchronous reset clears all valid bits, the
//   arm counter and the sequencer, and sets min_period to 10; the entry memory
//   itself is not cleared, entries are only used where their valid bit is set
//   ties on deadline go to the older arm stamp, then to the lower slot
`default_nettype none

module periodic_timer_table #(
    parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire ptt_pkg::t_cmd_item  i_item,
    output logic                     o_strobe,
    output ptt_pkg::t_result         o_result,
    input  wire                      i_cfg_we,
    input  wire  [15:0]              i_cfg_wdata
);

    localparam int               IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(MAX_TIMERS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    ptt_pkg::t_cmd_item    r_cmd;
    logic [31:0]           r_period_eff;
    logic [15:0]           r_min_period;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [31:0]           r_arm_cnt;
    logic                  r_issue;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_ev_vld;
    logic [IDX_W-1:0]      r_ev_idx;
    logic                  r_strobe;
    ptt_pkg::t_result      r_result;

    ptt_pkg::t_entry       rd_ent;
    ptt_pkg::t_scan_ctl    scan_ctl;
    ptt_pkg::t_pick        match;
    ptt_pkg::t_pick        best;
    logic [IDX_W-1:0]      match_slot;
    logic                  free_found;
    logic [IDX_W-1:0]      free_slot;
    logic [IDX_W-1:0]      best_slot;

    logic                  accept;
    logic [31:0]           min_ext;
    logic [31:0]           wait_diff;
    logic                  do_arm;
    logic                  set_new;
    logic                  kill_one;
    logic [IDX_W-1:0]      arm_slot;
    ptt_pkg::t_entry       arm_src;
    ptt_pkg::t_entry       w_wdata;
    logic                  w_we;
    ptt_pkg::t_result      n_result;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign min_ext = {16'd0, r_min_period};

    assign scan_ctl = '{
        clear:       accept,
        eval:        (r_state == S_SCAN) && r_ev_vld,
        entry_valid: r_valid[r_ev_idx],
        owner:       r_cmd.owner,
        tid:         r_cmd.tid
    };

    ptt_store #(
        .MAX_TIMERS (MAX_TIMERS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (arm_slot),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_ent)
    );

    ptt_scan #(
        .MAX_TIMERS (MAX_TIMERS),
        .IDX_W      (IDX_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_rd         (rd_ent),
        .i_idx        (r_ev_idx),
        .o_match      (match),
        .o_match_slot (match_slot),
        .o_free_found (free_found),
        .o_free_slot  (free_slot),
        .o_best       (best),
        .o_best_slot  (best_slot)
    );

    assign wait_diff = best.ent.deadline - r_cmd.now;

    always_comb begin
        n_result = '0;
        do_arm   = 1'b0;
        set_new  = 1'b0;
        kill_one = 1'b0;
        arm_slot = free_slot;
        arm_src  = '{owner: r_cmd.owner, tid: r_cmd.tid, period: r_period_eff,
                     deadline: 32'd0, arm_stamp: 32'd0};
        n_result.status = ptt_pkg::ST_OK;
        unique case (r_cmd.cmd)
            ptt_pkg::CMD_SET: begin
                if (match.found) begin
                    n_result.status = ptt_pkg::ST_EXISTS;
                end else if (!free_found) begin
                    n_result.status = ptt_pkg::ST_FULL;
                end else begin
                    do_arm  = 1'b1;
                    set_new = 1'b1;
                end
            end
            ptt_pkg::CMD_KILL: begin
                kill_one = match.found;
            end
            ptt_pkg::CMD_RESET: begin
                if (match.found) begin
                    do_arm   = 1'b1;
                    arm_slot = match_slot;
                    arm_src  = match.ent;
                end
            end
            ptt_pkg::CMD_CHECK: begin
                if (!best.found) begin
                    n_result.status = ptt_pkg::ST_EMPTY;
                end else if (!ptt_pkg::precedes(r_cmd.now, best.ent.deadline)) begin
                    n_result.status      = ptt_pkg::ST_FIRED;
                    n_result.fired_owner = best.ent.owner;
                    n_result.fired_id    = best.ent.tid;
                    do_arm               = 1'b1;
                    arm_slot             = best_slot;
                    arm_src              = best.ent;
                end else begin
                    n_result.status    = ptt_pkg::ST_WAITING;
                    n_result.remaining = wait_diff[30:0];
                end
            end
            default: begin
            end
        endcase
        w_wdata           = arm_src;
        w_wdata.deadline  = r_cmd.now + arm_src.period;
        w_wdata.arm_stamp = r_arm_cnt;
        w_we              = (r_state == S_DONE) && do_arm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_period <= ptt_pkg::MIN_PERIOD_RST;
            r_valid      <= '0;
            r_arm_cnt    <= 32'd0;
            r_issue      <= 1'b0;
            r_rd_idx     <= '0;
            r_ev_vld     <= 1'b0;
            r_ev_idx     <= '0;
            r_strobe     <= 1'b0;
            r_result     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_period <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (start) begin
                        r_state  <= S_SCAN;
                        r_issue  <= 1'b1;
                        r_rd_idx <= '0;
                        r_ev_vld <= 1'b0;
                    end
                end
                S_SCAN: begin
                    r_ev_vld <= r_issue;
                    r_ev_idx <= r_rd_idx;
                    if (r_issue) begin
                        if (r_rd_idx == LAST) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_rd_idx <= r_rd_idx + IDX_W'(1);
                        end
                    end
                    if (r_ev_vld && (r_cmd.cmd == ptt_pkg::CMD_KILL_ALL)
                        && r_valid[r_ev_idx] && (rd_ent.owner == r_cmd.owner)) begin
                        r_valid[r_ev_idx] <= 1'b0;
                    end
                    if (r_ev_vld && (r_ev_idx == LAST)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (set_new) begin
                        r_valid[free_slot] <= 1'b1;
                    end
                    if (kill_one) begin
                        r_valid[match_slot] <= 1'b0;
                    end
                    if (do_arm) begin
                        r_arm_cnt <= r_arm_cnt + 32'd1;
                    end
                    r_result <= n_result;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= i_item;
            r_period_eff <= (i_item.period < min_ext) ? min_ext : i_item.period;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after an accepted item");

    a_strobe_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_DONE))
        else $error("result strobe without a finished sweep");

    a_remaining_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ptt_pkg::ST_WAITING)) |-> (o_result.remaining == '0))
        else $error("ticks remaining given on a result that is not waiting");

    a_full_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ptt_pkg::ST_FULL)) |-> (&r_valid))
        else $error("table reported full with a free slot");

endmodule

`default_nettype wire

// ----- verif/periodic_timer_table_checker.sv -----
// checker for the periodic timer table: predicts each result item and compares it
module periodic_timer_table_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    input  wire                 busy,
    input  ptt_pkg::t_cmd_item  i_item,
    input  wire                 o_strobe,
    input  ptt_pkg::t_result    o_result,
    input  wire                 i_cfg_we,
    input  wire  [15:0]         i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_fired_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_SLOTS   = ptt_pkg::MAX_TIMERS_DEF;
    localparam int MAX_PRINT = 40;

    logic        tmr_valid  [N_SLOTS];
    logic [7:0]  tmr_owner  [N_SLOTS];
    logic [31:0] tmr_id     [N_SLOTS];
    logic [31:0] tmr_start  [N_SLOTS];
    logic [31:0] tmr_period [N_SLOTS];
    logic [31:0] tmr_stamp  [N_SLOTS];
    logic [31:0] arm_count;
    logic [15:0] min_period;

    ptt_pkg::t_result expected_results[$];

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_fired_count = 0;
    end

    // a lies behind b on the wrapping tick circle
    function automatic logic tick_lt(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic int lookup_timer(logic [7:0] own, logic [31:0] id);
        int hit;
        hit = -1;
        for (int i = N_SLOTS - 1; i >= 0; i--) begin
            if (tmr_valid[i] && tmr_owner[i] == own && tmr_id[i] == id) hit = i;
        end
        return hit;
    endfunction

    function automatic void rearm_timer(int slot, logic [31:0] now);
        tmr_start[slot] = now;
        tmr_stamp[slot] = arm_count;
        arm_count       = arm_count + 32'd1;
    endfunction

    function automatic ptt_pkg::t_result predict_timer_result(ptt_pkg::t_cmd_item it);
        ptt_pkg::t_result r;
        int               slot;
        logic [31:0]      best_dl;
        logic [31:0]      dl;
        r       = '0;
        r.status = ptt_pkg::ST_OK;
        slot    = -1;
        best_dl = '0;
        case (it.cmd)
            ptt_pkg::CMD_SET: begin
                if (lookup_timer(it.owner, it.tid) >= 0) begin
                    r.status = ptt_pkg::ST_EXISTS;
                end else begin
                    for (int i = N_SLOTS - 1; i >= 0; i--) begin
                        if (!tmr_valid[i]) slot = i;
                    end
                    if (slot < 0) begin
                        r.status = ptt_pkg::ST_FULL;
                    end else begin
                        tmr_valid[slot]  = 1'b1;
                        tmr_owner[slot]  = it.owner;
                        tmr_id[slot]     = it.tid;
                        tmr_period[slot] = (it.period < {16'd0, min_period}) ?
                                           {16'd0, min_period} : it.period;
                        rearm_timer(slot, it.now);
                    end
                end
            end
            ptt_pkg::CMD_KILL: begin
                slot = lookup_timer(it.owner, it.tid);
                if (slot >= 0) tmr_valid[slot] = 1'b0;
            end
            ptt_pkg::CMD_KILL_ALL: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (tmr_valid[i] && tmr_owner[i] == it.owner) tmr_valid[i] = 1'b0;
                end
            end
            ptt_pkg::CMD_RESET: begin
                slot = lookup_timer(it.owner, it.tid);
                if (slot >= 0) rearm_timer(slot, it.now);
            end
            ptt_pkg::CMD_CHECK: begin
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (tmr_valid[i]) begin
                        dl = tmr_start[i] + tmr_period[i];
                        if (slot < 0 || tick_lt(dl, best_dl) ||
                            (dl == best_dl && tick_lt(tmr_stamp[i], tmr_stamp[slot]))) begin
                            slot    = i;
                            best_dl = dl;
                        end
                    end
                end
                if (slot < 0) begin
                    r.status = ptt_pkg::ST_EMPTY;
                end else if (!tick_lt(it.now, best_dl)) begin
                    r.status      = ptt_pkg::ST_FIRED;
                    r.fired_owner = tmr_owner[slot];
                    r.fired_id    = tmr_id[slot];
                    rearm_timer(slot, it.now);
                end else begin
                    r.status    = ptt_pkg::ST_WAITING;
                    r.remaining = 31'(best_dl - it.now);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic flag_field(string name, logic [31:0] want_v, logic [31:0] got_v);
        o_fail_count++;
        if (o_fail_count <= MAX_PRINT)
            $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        ptt_pkg::t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < N_SLOTS; i++) tmr_valid[i] = 1'b0;
            arm_count  = '0;
            min_period = ptt_pkg::MIN_PERIOD_RST;
            expected_results.delete();
            o_pending = 0;
        end else begin
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= MAX_PRINT)
                        $display("%0t: result item with nothing expected, got %0h",
                                 $time, o_result);
                end else begin
                    want = expected_results.pop_front();
                    if (want.status == ptt_pkg::ST_FIRED) o_fired_count++;
                    if (o_result.status !== want.status)
                        flag_field("status", want.status, o_result.status);
                    if (o_result.fired_owner !== want.fired_owner)
                        flag_field("fired_owner", want.fired_owner, o_result.fired_owner);
                    if (o_result.fired_id !== want.fired_id)
                        flag_field("fired_id", want.fired_id, o_result.fired_id);
                    if (o_result.remaining !== want.remaining)
                        flag_field("remaining", want.remaining, o_result.remaining);
                end
            end
            if (i_cfg_we) min_period = i_cfg_wdata;
            if (start && !busy) expected_results.push_back(predict_timer_result(i_item));
            o_pending = expected_results.size();
        end
    end

endmodule

// ----- verif/periodic_timer_table_tb.sv -----
// testbench top for the periodic timer table: clock, reset, command stimulus and verdict
module periodic_timer_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY        = ptt_pkg::MAX_TIMERS_DEF + 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 80;
    localparam int N_PHASES       = 5;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    ptt_pkg::t_cmd_item i_item;
    logic               o_strobe;
    ptt_pkg::t_result   o_result;
    logic               i_cfg_we;
    logic [15:0]        i_cfg_wdata;

    int          fail_count;
    int          n_pending;
    int          n_fired;
    int          idle_cycles;
    int          n_sent;
    int          n_settings;
    int          calm_left;
    logic [31:0] tick;
    logic [15:0] cur_min_period;
    logic [15:0] phase_setting [N_PHASES];

    periodic_timer_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    periodic_timer_table_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_strobe      (o_strobe),
        .o_result      (o_result),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (n_pending),
        .o_fired_count (n_fired)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int draw_gap();
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm_left = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    task automatic send_item(ptt_pkg::t_cmd_item it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        n_sent++;
    endtask

    task automatic send_cmd(logic [2:0] cmd, logic [7:0] own, logic [31:0] id,
                            logic [31:0] per, logic [31:0] now);
        ptt_pkg::t_cmd_item it;
        it.cmd    = cmd;
        it.owner  = own;
        it.tid    = id;
        it.period = per;
        it.now    = now;
        send_item(it);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge i_clk); while (n_pending != 0);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_min_period(logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_min_period = value;
        n_settings++;
    endtask

    function automatic ptt_pkg::t_cmd_item random_command();
        ptt_pkg::t_cmd_item it;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.cmd = ptt_pkg::CMD_SET;
        else if (pick < 40) it.cmd = ptt_pkg::CMD_KILL;
        else if (pick < 44) it.cmd = ptt_pkg::CMD_KILL_ALL;
        else if (pick < 56) it.cmd = ptt_pkg::CMD_RESET;
        else if (pick < 96) it.cmd = ptt_pkg::CMD_CHECK;
        else                it.cmd = ptt_pkg::CMD_CHECK + 3'($urandom_range(1, 3));

        pick = $urandom_range(0, 9);
        if (pick < 8) it.owner = 8'($urandom_range(0, 3));
        else          it.owner = 8'($urandom_range(0, 255));
        if (pick == 9) it.owner = 8'hff;

        pick = $urandom_range(0, 9);
        if (pick < 7)       it.tid = $urandom_range(0, 5);
        else if (pick == 7) it.tid = 32'hffff_ffff - $urandom_range(0, 2);
        else                it.tid = $urandom;

        pick = $urandom_range(0, 9);
        if (pick < 4)       it.period = $urandom_range(0, 40);
        else if (pick < 6)  it.period = $urandom_range(0, 300);
        else if (pick < 8)  it.period = {16'd0, cur_min_period} + $urandom_range(0, 2) - 1;
        else                it.period = $urandom;

        pick = $urandom_range(0, 99);
        if (pick < 60)      tick = tick + $urandom_range(0, 8);
        else if (pick < 90) tick = tick + $urandom_range(0, 60);
        else if (pick < 98) tick = tick + $urandom_range(0, 70000);
        else                tick = $urandom;
        it.now = tick;
        return it;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_item      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        idle_cycles = 0;
        n_sent      = 0;
        n_settings  = 0;
        calm_left   = 0;
        tick        = '0;
        cur_min_period = ptt_pkg::MIN_PERIOD_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under the reset min_period
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'd0);
        send_cmd(ptt_pkg::CMD_SET,      8'd0,  32'd0,         32'd0,         32'd0);
        send_cmd(ptt_pkg::CMD_SET,      8'hff, 32'hffff_ffff, 32'hffff_ffff, 32'd0);
        send_cmd(ptt_pkg::CMD_SET,      8'd0,  32'd0,         32'd50,        32'd1);
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'd5);
        send_cmd(ptt_pkg::CMD_KILL_ALL, 8'hff, 32'd0,         32'd0,         32'd5);
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'd5);
        // deadline equal to now fires
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'd10);
        send_cmd(ptt_pkg::CMD_SET,      8'd1,  32'd7,         32'd20,        32'd10);
        // equal deadlines, older arm stamp wins
        send_cmd(ptt_pkg::CMD_SET,      8'd2,  32'd8,         32'd9,         32'd10);
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'd25);
        send_cmd(ptt_pkg::CMD_RESET,    8'd1,  32'd7,         32'd0,         32'd25);
        send_cmd(ptt_pkg::CMD_KILL,     8'd9,  32'd9,         32'd0,         32'd26);
        send_cmd(ptt_pkg::CMD_RESET,    8'd9,  32'd9,         32'd0,         32'd26);
        send_cmd(ptt_pkg::CMD_KILL,     8'd2,  32'd8,         32'd0,         32'd27);
        for (int c = 1; c <= 3; c++)
            send_cmd(ptt_pkg::CMD_CHECK + 3'(c), 8'($urandom), $urandom, $urandom, $urandom);
        // deadline wraps past zero
        send_cmd(ptt_pkg::CMD_SET,      8'd3,  32'h8000_0000, 32'h20,        32'hffff_fff0);
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'hffff_ffff);
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'h10);
        send_cmd(ptt_pkg::CMD_SET,      8'd4,  32'd1,         32'h7fff_fff0, 32'h10);
        send_cmd(ptt_pkg::CMD_CHECK,    8'd0,  32'd0,         32'd0,         32'h11);
        tick = 32'h11;
        wait_for_results();

        phase_setting[0] = 16'd0;
        phase_setting[1] = 16'hffff;
        phase_setting[2] = 16'd1;
        phase_setting[3] = 16'($urandom_range(0, 65535));
        phase_setting[4] = ptt_pkg::MIN_PERIOD_RST;
        for (int p = 0; p < N_PHASES; p++) begin
            write_min_period(phase_setting[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_command());
            wait_for_results();
        end

        $display("sent %0d command items: every command, unused codes, full table, tick wrap",
                 n_sent);
        $display("%0d min_period settings from 0 to 65535, %0d timers fired",
                 n_settings, n_fired);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/ptt_pkg.sv
sv/ptt_store.sv
sv/ptt_scan.sv
sv/periodic_timer_table.sv
verif/periodic_timer_table_checker.sv
verif/periodic_timer_table_tb.sv
